/* rtl/cia_pkg.sv */
// shared types, opcodes and status codes for the checked integer alu
`default_nettype none
package cia_pkg;

	// opcodes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MOD = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	// control that travels with an item along the row
	typedef struct packed {
		logic       vld;
		logic [2:0] op;
		logic       neg_q;    // quotient or product is negative
		logic       neg_a;    // dividend was negative
		logic       early;    // status already settled before the row
		logic [1:0] st;
	} ctl_t;

endpackage
`default_nettype wire

/* rtl/cia_cell.sv */
// one cell of the row: a restoring divide step and a shift-add multiply step
`default_nettype none
module cia_cell #(
	parameter int W = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire cia_pkg::ctl_t      ctl_i,
	input  wire logic [W-1:0]       rem_i,   // partial remainder
	input  wire logic [W-1:0]       quo_i,   // dividend bits shifting into quotient
	input  wire logic [W-1:0]       dvs_i,   // divisor magnitude
	input  wire logic [2*W-1:0]     acc_i,   // product accumulator
	input  wire logic [2*W-1:0]     mcd_i,   // multiplicand magnitude, shifted to this bit
	input  wire logic [W-1:0]       mpr_i,   // multiplier bits, lsb first
	output cia_pkg::ctl_t           ctl_o,
	output logic [W-1:0]            rem_o,
	output logic [W-1:0]            quo_o,
	output logic [W-1:0]            dvs_o,
	output logic [2*W-1:0]          acc_o,
	output logic [2*W-1:0]          mcd_o,
	output logic [W-1:0]            mpr_o
);

	logic [W:0]     trial;
	logic [W:0]     shifted;
	logic [2*W-1:0] acc_n;

	// divide step: bring down the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_i, quo_i[W-1]};
		trial   = shifted - {1'b0, dvs_i};
	end

	// multiply step: add multiplicand at this bit position
	always_comb begin
		acc_n = acc_i;
		if (mpr_i[0]) begin
			acc_n = acc_i + mcd_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (adv) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (trial[W]) begin
				rem_o <= shifted[W-1:0];
				quo_o <= {quo_i[W-2:0], 1'b0};
			end else begin
				rem_o <= trial[W-1:0];
				quo_o <= {quo_i[W-2:0], 1'b1};
			end
			dvs_o <= dvs_i;
			acc_o <= acc_n;
			mcd_o <= {mcd_i[2*W-2:0], 1'b0};
			mpr_o <= {1'b0, mpr_i[W-1:1]};
		end
	end

endmodule
`default_nettype wire

/* rtl/checked_integer_alu.sv */
// top level: checked signed alu built as a row of divide/multiply cells
// pipeline: WIDTH cell registers, then one output register
// throughput: one item per cycle unless stalled; the row of WIDTH cells advances together
// a stall on the output holds the whole row, input stall follows it
// reset: asynchronous active low, clears all valid flags; payload is not reset
`default_nettype none
module checked_integer_alu #(
	parameter int WIDTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         op,
	input  wire logic signed [63:0] lhs,
	input  wire logic signed [63:0] rhs,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [63:0]      value,
	output logic [1:0]              status
);

	localparam int W = WIDTH;

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// operand decode
	logic [W-1:0] a, b, ma, mb, maxv, minv;
	logic         sa, sb;
	logic [W:0]   sum, dif;
	assign a    = lhs[W-1:0];
	assign b    = rhs[W-1:0];
	assign sa   = a[W-1];
	assign sb   = b[W-1];
	assign ma   = sa ? (~a + 1'b1) : a;
	assign mb   = sb ? (~b + 1'b1) : b;
	assign maxv = {1'b0, {(W-1){1'b1}}};
	assign minv = {1'b1, {(W-1){1'b0}}};
	assign sum  = {sa, a} + {sb, b};
	assign dif  = {sa, a} - {sb, b};

	cia_pkg::ctl_t ctl_in;
	logic [W-1:0]  early_v;
	always_comb begin
		ctl_in       = '0;
		ctl_in.vld   = in_valid;
		ctl_in.op    = op;
		ctl_in.neg_q = sa ^ sb;
		ctl_in.neg_a = sa;
		ctl_in.st    = cia_pkg::ST_OK;
		early_v      = '0;
		unique case (op)
			cia_pkg::OP_ADD: begin
				ctl_in.early = 1'b1;
				if (sum[W] != sum[W-1]) ctl_in.st = cia_pkg::ST_OVF;
				else early_v = sum[W-1:0];
			end
			cia_pkg::OP_SUB: begin
				ctl_in.early = 1'b1;
				if (dif[W] != dif[W-1]) ctl_in.st = cia_pkg::ST_OVF;
				else early_v = dif[W-1:0];
			end
			cia_pkg::OP_MUL: ctl_in.early = 1'b0;
			cia_pkg::OP_DIV: begin
				if (b == '0) begin
					ctl_in.early = 1'b1;
					ctl_in.st    = cia_pkg::ST_DIV0;
				end else if (a == minv && b == '1) begin
					ctl_in.early = 1'b1;
					ctl_in.st    = cia_pkg::ST_OVF;
				end
			end
			cia_pkg::OP_MOD: begin
				if (b == '0) begin
					ctl_in.early = 1'b1;
					ctl_in.st    = cia_pkg::ST_DIV0;
				end
			end
			default: ctl_in.early = 1'b1;
		endcase
	end

	// row of cells
	cia_pkg::ctl_t  ctl [0:W];
	logic [W-1:0]   rem [0:W];
	logic [W-1:0]   quo [0:W];
	logic [W-1:0]   dvs [0:W];
	logic [2*W-1:0] acc [0:W];
	logic [2*W-1:0] mcd [0:W];
	logic [W-1:0]   mpr [0:W];
	logic [W-1:0]   ev  [0:W];

	assign ctl[0] = ctl_in;
	assign rem[0] = '0;
	assign quo[0] = ma;
	assign dvs[0] = mb;
	assign acc[0] = '0;
	assign mcd[0] = {{W{1'b0}}, ma};
	assign mpr[0] = mb;
	assign ev[0]  = early_v;

	for (genvar i = 0; i < W; i++) begin : g_row
		cia_cell #(.W(W)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.ctl_i(ctl[i]), .rem_i(rem[i]), .quo_i(quo[i]), .dvs_i(dvs[i]),
			.acc_i(acc[i]), .mcd_i(mcd[i]), .mpr_i(mpr[i]),
			.ctl_o(ctl[i+1]), .rem_o(rem[i+1]), .quo_o(quo[i+1]),
			.dvs_o(dvs[i+1]), .acc_o(acc[i+1]), .mcd_o(mcd[i+1]),
			.mpr_o(mpr[i+1])
		);
		// early result rides alongside the row
		always_ff @(posedge clk) begin
			if (adv) ev[i+1] <= ev[i];
		end
	end

	// final stage: sign fix, range check, modulo adjust
	cia_pkg::ctl_t  c;
	logic [W-1:0]   q, r, d, prod_lo, res;
	logic [W-1:0]   prod_hi;
	logic [1:0]     st;
	always_comb begin
		c       = ctl[W];
		q       = quo[W];
		r       = rem[W];
		d       = dvs[W];
		prod_lo = acc[W][W-1:0];
		prod_hi = acc[W][2*W-1:W];
		st      = c.st;
		res     = '0;
		if (c.early) begin
			res = ev[W];
		end else begin
			priority case (c.op)
				cia_pkg::OP_MUL: begin
					if (prod_hi != '0) st = cia_pkg::ST_OVF;
					else if (c.neg_q) begin
						if (prod_lo > minv) st = cia_pkg::ST_OVF;
						else res = ~prod_lo + 1'b1;
					end else begin
						if (prod_lo > maxv) st = cia_pkg::ST_OVF;
						else res = prod_lo;
					end
				end
				cia_pkg::OP_DIV: res = c.neg_q ? (~q + 1'b1) : q;
				default: res = (c.neg_a && r != '0) ? (d - r) : r;
			endcase
		end
		if (st != cia_pkg::ST_OK) res = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= c.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value  <= 64'(signed'(res));
			status <= st;
		end
	end

	// status code 3 is never produced
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	// an error result carries zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != cia_pkg::ST_OK) |-> value == '0)
		else $error("nonzero value on error");
	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(value) && $stable(status))
		else $error("result changed under stall");

endmodule
`default_nettype wire

/* tb/tb_alu_checker.sv */
// checker for the checked integer alu: watches both channels, predicts and compares
module tb_alu_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [2:0]         op,
	input  wire logic signed [63:0] lhs,
	input  wire logic signed [63:0] rhs,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [63:0] value,
	input  wire logic [1:0]         status,
	output int                      errors,
	output int                      pending,
	output int                      results_seen
);

	typedef struct packed {
		logic signed [63:0] val;
		logic [1:0]         st;
	} alu_result_t;

	alu_result_t expected_results[$];

	// overflow-checked arithmetic on 64-bit signed operands
	function automatic alu_result_t compute_alu(logic [2:0] code, logic signed [63:0] a,
			logic signed [63:0] b);
		alu_result_t r;
		logic signed [65:0] wide;
		logic signed [127:0] prod;
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] rem;
		r.val = '0;
		r.st  = cia_pkg::ST_OK;
		case (code)
			cia_pkg::OP_ADD: begin
				wide = 66'(a) + 66'(b);
				if (wide > 66'sh0_7FFF_FFFF_FFFF_FFFF || wide < -66'sh0_8000_0000_0000_0000)
					r.st = cia_pkg::ST_OVF;
				else
					r.val = wide[63:0];
			end
			cia_pkg::OP_SUB: begin
				wide = 66'(a) - 66'(b);
				if (wide > 66'sh0_7FFF_FFFF_FFFF_FFFF || wide < -66'sh0_8000_0000_0000_0000)
					r.st = cia_pkg::ST_OVF;
				else
					r.val = wide[63:0];
			end
			cia_pkg::OP_MUL: begin
				prod = 128'(a) * 128'(b);
				if (prod != 128'($signed(prod[63:0])))
					r.st = cia_pkg::ST_OVF;
				else
					r.val = prod[63:0];
			end
			cia_pkg::OP_DIV: begin
				if (b == 0)
					r.st = cia_pkg::ST_DIV0;
				else if (a == 64'sh8000_0000_0000_0000 && b == -64'sd1)
					r.st = cia_pkg::ST_OVF;
				else
					r.val = a / b;
			end
			cia_pkg::OP_MOD: begin
				if (b == 0) begin
					r.st = cia_pkg::ST_DIV0;
				end else begin
					ua  = a[63] ? -a : a;
					ub  = b[63] ? -b : b;
					rem = ua % ub;
					if (a[63] && rem != 0)
						rem = ub - rem;
					r.val = rem;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	assign pending = expected_results.size();

	// predict on accepted items, compare on accepted results
	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && in_valid && !in_stall)
			expected_results.push_back(compute_alu(op, lhs, rhs));
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want = expected_results.pop_front();
				if (value !== want.val)
					report_mismatch($sformatf("value %h, wanted %h", value, want.val));
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, wanted %0d", status, want.st));
			end
		end
	end

	initial begin
		errors = 0;
		results_seen = 0;
	end
endmodule

/* tb/tb_top.sv */
// top of the checked integer alu testbench: stimulus, stalls and verdict
module tb_top;

	localparam int RANDOM_ITEMS = 1800;
	localparam int LATENCY = 66;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] op;
	logic signed [63:0] lhs;
	logic signed [63:0] rhs;
	logic out_valid;
	logic out_stall;
	logic signed [63:0] value;
	logic [1:0] status;
	int errors;
	int pending;
	int results_seen;
	int cycle_count;
	int items_sent;
	bit quiet_tail;
	bit hold_done;

	checked_integer_alu DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .lhs(lhs), .rhs(rhs), .out_valid(out_valid), .out_stall(out_stall),
		.value(value), .status(status)
	);

	tb_alu_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .lhs(lhs), .rhs(rhs), .out_valid(out_valid), .out_stall(out_stall),
		.value(value), .status(status), .errors(errors), .pending(pending),
		.results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// operand with bias toward the edges of the range
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
			1: return 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
			2: return 64'($signed($urandom_range(0, 8)) - 4);
			3: return 64'($signed($urandom()));
			4: return {{32{1'b0}}, $urandom()} << $urandom_range(0, 32);
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// offer one item and hold it until accepted
	task automatic send_item(logic [2:0] code, logic [63:0] a, logic [63:0] b);
		int gap;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op  <= code;
		lhs <= a;
		rhs <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// receiver: one long hold-off early, then random stall bursts
	initial begin
		int burst;
		out_stall = 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		repeat (40) @(posedge clk);
		out_stall <= 1'b1;
		repeat (200) @(posedge clk);
		out_stall <= 1'b0;
		hold_done = 1;
		forever begin
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (!quiet_tail && $urandom_range(0, 2) == 0) begin
				burst = $urandom_range(1, 14);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("checked_integer_alu regression: fail");
			$finish;
		end
	end

	initial begin
		logic [63:0] minv;
		logic [63:0] maxv;
		logic [2:0] code;
		cycle_count = 0;
		items_sent = 0;
		quiet_tail = 0;
		minv = 64'h8000_0000_0000_0000;
		maxv = 64'h7FFF_FFFF_FFFF_FFFF;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = '0;
		lhs = '0;
		rhs = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and each special case
		send_item(cia_pkg::OP_ADD, maxv, 64'd1);
		send_item(cia_pkg::OP_ADD, minv, -64'd1);
		send_item(cia_pkg::OP_ADD, maxv, minv);
		send_item(cia_pkg::OP_SUB, minv, 64'd1);
		send_item(cia_pkg::OP_SUB, 64'd0, minv);
		send_item(cia_pkg::OP_SUB, -64'd1, minv);
		send_item(cia_pkg::OP_MUL, minv, 64'd1);
		send_item(cia_pkg::OP_MUL, minv, -64'd1);
		send_item(cia_pkg::OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
		send_item(cia_pkg::OP_MUL, -64'h1_0000_0000, 64'h8000_0000);
		send_item(cia_pkg::OP_MUL, maxv, maxv);
		send_item(cia_pkg::OP_DIV, 64'd7, 64'd0);
		send_item(cia_pkg::OP_DIV, minv, -64'd1);
		send_item(cia_pkg::OP_DIV, -64'd7, 64'd2);
		send_item(cia_pkg::OP_DIV, maxv, minv);
		send_item(cia_pkg::OP_MOD, 64'd7, 64'd0);
		send_item(cia_pkg::OP_MOD, minv, -64'd1);
		send_item(cia_pkg::OP_MOD, -64'd7, 64'd3);
		send_item(cia_pkg::OP_MOD, -64'd6, -64'd3);
		send_item(cia_pkg::OP_MOD, minv, maxv);
		send_item(3'd5, maxv, minv);
		send_item(3'd6, 64'd1, 64'd1);
		send_item(3'd7, {64{1'b1}}, 64'd0);

		// random items; the last stretch runs with no idling
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - 200)
				quiet_tail = 1;
			code = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send_item(code, pick_operand(),
				($urandom_range(0, 15) == 0) ? 64'd0 : pick_operand());
		end
		in_valid <= 1'b0;

		while (pending != 0 || !hold_done) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered %0d items over all opcodes, edge operands and error cases", items_sent);
		$display("checked %0d results with random idling and a long output hold-off",
			results_seen);
		if (errors == 0 && pending == 0)
			$display("checked_integer_alu regression: pass");
		else
			$display("checked_integer_alu regression: fail");
		$finish;
	end
endmodule
